// File: src/cp1251_pkg.sv
// Shared types, constants and the code point table of the Windows-1251 to UTF-8 transcoder.
// No dependencies; the decode, encode, serial and top-level files import this package.
`default_nettype none
package cp1251_pkg;

  localparam int CP_W = 16;

  typedef logic [CP_W-1:0] code_point_t;
  typedef logic [1:0]      byte_count_t;

  localparam logic [7:0]  ASCII_LIMIT    = 8'h80;
  localparam logic [7:0]  CYR_FIRST      = 8'hC0;
  localparam code_point_t CYR_BASE       = 16'h0410;
  localparam code_point_t TWO_BYTE_LIMIT = 16'h0800;

  localparam logic [2:0] LEAD2_PREFIX = 3'b110;
  localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
  localparam logic [1:0] CONT_PREFIX  = 2'b10;

  localparam byte_count_t ONE_BYTE   = 2'd1;
  localparam byte_count_t TWO_BYTES  = 2'd2;
  localparam byte_count_t THREE_BYTES = 2'd3;

  // Code points of bytes 0x80 to 0xBF; the undefined 0x98 maps to '?'.
  localparam code_point_t HIGH_ROM [64] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h003F, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  typedef struct packed {
    code_point_t cp;
    logic        chunk_end;
  } cp_item_t;

  typedef struct packed {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    byte_count_t n;
    logic        chunk_end;
  } enc_item_t;

endpackage
`default_nettype wire

// File: src/cp1251_byte_if.sv
// Request channel that carries one Windows-1251 byte and its chunk-end flag.
// No dependencies.
`default_nettype none
interface cp1251_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface
`default_nettype wire

// File: src/cp1251_utf8_if.sv
// Request channel that carries one UTF-8 byte with its character and chunk flags.
// No dependencies.
`default_nettype none
interface cp1251_utf8_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       char_last;
  logic       chunk_done;

  modport source (output valid, output out_byte, output char_last, output chunk_done,
                  input ready);
  modport sink   (input valid, input out_byte, input char_last, input chunk_done,
                  output ready);
endinterface
`default_nettype wire

// File: src/cp1251_decode.sv
// First stage: maps a Windows-1251 byte to its code point and registers it.
// Depends on cp1251_pkg and cp1251_byte_if.
`default_nettype none
module cp1251_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  cp1251_byte_if.sink        src,
  output cp1251_pkg::cp_item_t item,
  output logic               item_valid,
  input  wire logic          item_ready
);
  import cp1251_pkg::*;

  code_point_t cp_next;

  always_comb begin
    if (src.in_byte < ASCII_LIMIT) begin
      cp_next = {{(CP_W-8){1'b0}}, src.in_byte};
    end else if (src.in_byte < CYR_FIRST) begin
      cp_next = HIGH_ROM[src.in_byte[5:0]];
    end else begin
      cp_next = CYR_BASE + {{(CP_W-6){1'b0}}, src.in_byte[5:0]};
    end
  end

  assign src.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (src.ready) begin
      item_valid <= src.valid;
    end
    if (src.ready && src.valid) begin
      item.cp        <= cp_next;
      item.chunk_end <= src.chunk_end;
    end
  end
endmodule
`default_nettype wire

// File: src/cp1251_encode.sv
// Second stage: forms the one to three UTF-8 bytes of a code point and registers them.
// Depends on cp1251_pkg.
`default_nettype none
module cp1251_encode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  cp1251_pkg::cp_item_t  src,
  input  wire logic            src_valid,
  output logic                 src_ready,
  output cp1251_pkg::enc_item_t enc,
  output logic                 enc_valid,
  input  wire logic            enc_ready
);
  import cp1251_pkg::*;

  enc_item_t enc_next;

  always_comb begin
    enc_next.chunk_end = src.chunk_end;
    enc_next.b1        = {CONT_PREFIX, src.cp[11:6]};
    enc_next.b2        = {CONT_PREFIX, src.cp[5:0]};
    if (src.cp < {{(CP_W-8){1'b0}}, ASCII_LIMIT}) begin
      enc_next.b0 = src.cp[7:0];
      enc_next.n  = ONE_BYTE;
    end else if (src.cp < TWO_BYTE_LIMIT) begin
      // The low six bits become the second and final byte.
      enc_next.b0 = {LEAD2_PREFIX, src.cp[10:6]};
      enc_next.b1 = {CONT_PREFIX, src.cp[5:0]};
      enc_next.n  = TWO_BYTES;
    end else begin
      enc_next.b0 = {LEAD3_PREFIX, src.cp[15:12]};
      enc_next.n  = THREE_BYTES;
    end
  end

  assign src_ready = !enc_valid || enc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid <= 1'b0;
    end else if (src_ready) begin
      enc_valid <= src_valid;
    end
    if (src_ready && src_valid) begin
      enc <= enc_next;
    end
  end
endmodule
`default_nettype wire

// File: src/cp1251_serial.sv
// Output stage: holds one encoded character and shifts its bytes out one per cycle while the sink is ready.
// Depends on cp1251_pkg and cp1251_utf8_if.
`default_nettype none
module cp1251_serial (
  input  wire logic            clk,
  input  wire logic            rst,
  input  cp1251_pkg::enc_item_t src,
  input  wire logic            src_valid,
  output logic                 src_ready,
  cp1251_utf8_if.source        dst
);
  import cp1251_pkg::*;

  logic        valid;
  byte_count_t cnt;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic        chunk_end;
  logic        on_last;
  logic        fire;

  assign on_last = (cnt == ONE_BYTE);
  assign fire    = valid && dst.ready;
  // A new character may load in the same cycle that the last byte is taken.
  assign src_ready = !valid || (dst.ready && on_last);

  assign dst.valid      = valid;
  assign dst.out_byte   = b0;
  assign dst.char_last  = on_last;
  assign dst.chunk_done = on_last && chunk_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (src_ready) begin
      valid <= src_valid;
    end
    if (src_ready && src_valid) begin
      b0        <= src.b0;
      b1        <= src.b1;
      b2        <= src.b2;
      cnt       <= src.n;
      chunk_end <= src.chunk_end;
    end else if (fire && !on_last) begin
      b0  <= b1;
      b1  <= b2;
      cnt <= cnt - ONE_BYTE;
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid |-> cnt != 2'd0)
    else $error("serializer holds a character with no bytes left");

  a_cont_follows: assert property (@(posedge clk) disable iff (rst)
    fire && !on_last |=> valid && b0[7:6] == CONT_PREFIX)
    else $error("byte after a non-final byte is not a continuation byte");

  a_three_lead: assert property (@(posedge clk) disable iff (rst)
    valid && cnt == THREE_BYTES |-> b0[7:4] == LEAD3_PREFIX)
    else $error("three-byte character does not start with a three-byte lead");

  a_single_ascii: assert property (@(posedge clk) disable iff (rst)
    src_ready && src_valid && src.n == ONE_BYTE |=> !b0[7])
    else $error("single-byte character loaded with the high bit set");
endmodule
`default_nettype wire

// File: src/cp1251_to_utf8_transcoder_unit.sv
// Windows-1251 to UTF-8 transcoder, top level.
// The first UTF-8 byte of a character is offered once it has passed the decode, encode and serial registers.
// Throughput: one input byte per cycle for ASCII while the output is ready; for characters that encode to
// 2 or 3 bytes, the output stage, which sends one byte per cycle, takes no new one until the last byte is taken.
// Reset (rst, synchronous) clears the valid bit of each of the three stages; no memories.
`default_nettype none
module cp1251_to_utf8_transcoder_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  cp1251_byte_if.sink   cp_bytes,
  cp1251_utf8_if.source utf8_bytes
);
  import cp1251_pkg::*;

  cp_item_t  cp_item;
  logic      cp_valid;
  logic      cp_ready;
  enc_item_t enc_item;
  logic      enc_valid;
  logic      enc_ready;

  cp1251_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .src        (cp_bytes),
    .item       (cp_item),
    .item_valid (cp_valid),
    .item_ready (cp_ready)
  );

  cp1251_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .src       (cp_item),
    .src_valid (cp_valid),
    .src_ready (cp_ready),
    .enc       (enc_item),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready)
  );

  cp1251_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .src       (enc_item),
    .src_valid (enc_valid),
    .src_ready (enc_ready),
    .dst       (utf8_bytes)
  );
endmodule
`default_nettype wire
